// File: design/key_debounce_repeat_scanner_core_defines.svh
// ----------------------------------------------------------------------------
// key_debounce_repeat_scanner_core_defines
// Assertion macros used by the scanner core RTL.
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_REPEAT_SCANNER_CORE_DEFINES_SVH
`define KEY_DEBOUNCE_REPEAT_SCANNER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KDRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define KDRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/kdrs_pkg.sv
// ----------------------------------------------------------------------------
// kdrs_pkg
// Types, codes and defaults for the key debounce / repeat scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package kdrs_pkg;

    localparam int NUM_SOURCES_DEF = 8;
    localparam int TIME_BITS_DEF   = 32;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_START = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_EVERY = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_REPEAT_MASK  = 3'd4;

    localparam logic [15:0] DEBOUNCE_RST     = 16'd30;
    localparam logic [15:0] LONG_PRESS_RST   = 16'd600;
    localparam logic [15:0] REPEAT_START_RST = 16'd400;
    localparam logic [15:0] REPEAT_EVERY_RST = 16'd120;
    localparam logic [7:0]  REPEAT_MASK_RST  = 8'd94;

    localparam logic [3:0] ACT_BACK = 4'd8;
    localparam logic [3:0] ACT_WAKE = 4'd9;

    typedef enum logic [1:0] {
        KIND_PRESS,
        KIND_RELEASE,
        KIND_REPEAT,
        KIND_LONG
    } t_kind;

    typedef struct packed {
        logic       emit;
        t_kind      kind;
        logic [3:0] action;
        logic [2:0] source;
        logic       wake_supp;
    } t_event;

    typedef struct packed {
        logic [15:0] debounce;
        logic [15:0] long_press;
        logic [15:0] repeat_start;
        logic [15:0] repeat_every;
        logic [7:0]  repeat_mask;
    } t_cfg;

endpackage

`default_nettype wire

// File: design/kdrs_state_ram.sv
// ----------------------------------------------------------------------------
// kdrs_state_ram
// Per-source state memory, one write and one registered read per cycle.
// Entries never written read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module kdrs_state_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 100,
    parameter int AW    = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

`default_nettype wire

// File: design/kdrs_update.sv
// ----------------------------------------------------------------------------
// kdrs_update
// Modify step of the read-modify-write: debounce, press/release, long press,
// auto-repeat and wake handling for one source entry.
// ----------------------------------------------------------------------------
`default_nettype none

module kdrs_update #(
    parameter int TIME_BITS = 32,
    parameter int EW        = 4 + 3 * 32
) (
    input  wire logic                 i_cmd,
    input  wire logic                 i_in_range,
    input  wire logic [2:0]           i_source,
    input  wire logic                 i_raw_down,
    input  wire logic [TIME_BITS-1:0] i_now,
    input  wire logic                 i_awake_value,
    input  wire logic                 i_awake,
    input  wire logic                 i_repeatable,
    input  wire kdrs_pkg::t_cfg       i_cfg,
    input  wire logic [EW-1:0]        i_entry,
    output logic      [EW-1:0]        o_entry,
    output logic                      o_we,
    output logic                      o_awake,
    output kdrs_pkg::t_event          o_event
);

    import kdrs_pkg::*;

    logic                 lr, sd, ls, sp;
    logic [TIME_BITS-1:0] rct, pt, nrt;
    logic [TIME_BITS-1:0] d_raw, d_press, d_rep;
    logic                 is_go;

    always_comb begin
        {lr, rct, sd, pt, nrt, ls, sp} = i_entry;
        is_go   = (i_source == 3'd0);
        o_we    = 1'b0;
        o_awake = i_awake;
        o_event = '0;
        o_event.source = i_source;
        o_event.action = 4'(i_source);
        d_raw   = '0;
        d_press = '0;
        d_rep   = '0;

        if (i_cmd) begin
            o_awake = i_awake_value;
        end else if (i_in_range) begin
            o_we = 1'b1;
            if (i_raw_down != lr) begin
                lr  = i_raw_down;
                rct = i_now;
            end
            d_raw = i_now - rct;
            if (d_raw < TIME_BITS'(i_cfg.debounce) || i_raw_down == sd) begin
                // no stable change: long press and repeat checks
                if (sd) begin
                    d_press = i_now - pt;
                    d_rep   = i_now - nrt;
                    if (!ls && d_press >= TIME_BITS'(i_cfg.long_press)) begin
                        ls = 1'b1;
                        if (!sp && is_go) begin
                            o_event.emit   = 1'b1;
                            o_event.kind   = KIND_LONG;
                            o_event.action = ACT_BACK;
                        end
                    end else if (i_repeatable && !sp && !ls && !d_rep[TIME_BITS-1]) begin
                        nrt = i_now + TIME_BITS'(i_cfg.repeat_every);
                        o_event.emit = 1'b1;
                        o_event.kind = KIND_REPEAT;
                    end
                end
            end else begin
                sd = i_raw_down;
                if (i_raw_down) begin
                    ls  = 1'b0;
                    sp  = 1'b0;
                    pt  = i_now;
                    nrt = i_now + TIME_BITS'(i_cfg.repeat_start);
                    o_event.emit = 1'b1;
                    o_event.kind = KIND_PRESS;
                    if (!i_awake) begin
                        o_awake = 1'b1;
                        sp      = 1'b1;
                        o_event.action    = ACT_WAKE;
                        o_event.wake_supp = 1'b1;
                    end
                end else if (!is_go) begin
                    if (sp) begin
                        sp = 1'b0;
                    end else begin
                        o_event.emit = 1'b1;
                        o_event.kind = KIND_RELEASE;
                    end
                end
            end
        end
        o_entry = {lr, rct, sd, pt, nrt, ls, sp};
    end

endmodule

`default_nettype wire

// File: design/key_debounce_repeat_scanner_core.sv
// Pipeline: at the accepting edge the input word enters the read stage and the state memory
// is read; the update result enters the output register when the read stage advances.
// Throughput: one input word per cycle unless the output stalls; one read and one write port
// on the state memory carry one read-modify-write per cycle, with write-to-read forwarding.
// Reset: synchronous, clears all per-source state at once through valid bits,
// display asleep, registers to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
// key_debounce_repeat_scanner_core
// Top level: config registers, read stage, update stage and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_debounce_repeat_scanner_core_defines.svh"

module key_debounce_repeat_scanner_core #(
    parameter int NUM_SOURCES = kdrs_pkg::NUM_SOURCES_DEF,
    parameter int TIME_BITS   = kdrs_pkg::TIME_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [kdrs_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [kdrs_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_cmd,
    input  wire logic [2:0]                         i_source,
    input  wire logic                               i_raw_down,
    input  wire logic [31:0]                        i_now_ms,
    input  wire logic                               i_awake_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [1:0]                              o_event_kind,
    output logic [3:0]                              o_action_code,
    output logic [2:0]                              o_event_source,
    output logic [31:0]                             o_timestamp,
    output logic                                    o_wake_suppressed
);

    import kdrs_pkg::*;

    localparam int AW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int EW = 4 + 3 * TIME_BITS;

    // config
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce     <= DEBOUNCE_RST;
            r_cfg.long_press   <= LONG_PRESS_RST;
            r_cfg.repeat_start <= REPEAT_START_RST;
            r_cfg.repeat_every <= REPEAT_EVERY_RST;
            r_cfg.repeat_mask  <= REPEAT_MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DEBOUNCE:     r_cfg.debounce     <= i_cfg_data;
                REG_LONG_PRESS:   r_cfg.long_press   <= i_cfg_data;
                REG_REPEAT_START: r_cfg.repeat_start <= i_cfg_data;
                REG_REPEAT_EVERY: r_cfg.repeat_every <= i_cfg_data;
                REG_REPEAT_MASK:  r_cfg.repeat_mask  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // handshake
    logic in_accept, s1_adv;
    logic r_s1_valid;
    logic r_out_valid;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    // read stage
    logic [31:0]   src_ext;
    logic          in_range;
    logic [AW-1:0] raddr;

    assign src_ext  = 32'(i_source);
    assign in_range = (src_ext < 32'(NUM_SOURCES));
    assign raddr    = src_ext[AW-1:0];

    logic                 r_s1_cmd, r_s1_in_range, r_s1_raw, r_s1_awake_val;
    logic [2:0]           r_s1_src;
    logic [AW-1:0]        r_s1_addr;
    logic [TIME_BITS-1:0] r_s1_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd       <= i_cmd;
            r_s1_in_range  <= in_range;
            r_s1_raw       <= i_raw_down;
            r_s1_awake_val <= i_awake_value;
            r_s1_src       <= i_source;
            r_s1_addr      <= raddr;
            r_s1_now       <= TIME_BITS'(i_now_ms);
        end
    end

    // state memory and forwarding of the last write
    logic [EW-1:0] ram_rdata, s1_entry, n_entry;
    logic          n_we, mem_we;
    logic          r_fwd_valid;
    logic [AW-1:0] r_fwd_addr;
    logic [EW-1:0] r_fwd_data;

    assign mem_we = s1_adv && n_we;

    kdrs_state_ram #(
        .DEPTH (NUM_SOURCES),
        .WIDTH (EW),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (in_accept && in_range && !i_cmd),
        .i_raddr (raddr),
        .o_rdata (ram_rdata),
        .i_we    (mem_we),
        .i_waddr (r_s1_addr),
        .i_wdata (n_entry)
    );

    // forward register always mirrors the memory contents of r_fwd_addr
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (mem_we) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= n_entry;
        end
    end

    assign s1_entry = (r_fwd_valid && r_fwd_addr == r_s1_addr) ? r_fwd_data : ram_rdata;

    // update stage
    logic   r_display_awake, n_awake;
    t_event n_event;

    kdrs_update #(
        .TIME_BITS (TIME_BITS),
        .EW        (EW)
    ) u_update (
        .i_cmd         (r_s1_cmd),
        .i_in_range    (r_s1_in_range),
        .i_source      (r_s1_src),
        .i_raw_down    (r_s1_raw),
        .i_now         (r_s1_now),
        .i_awake_value (r_s1_awake_val),
        .i_awake       (r_display_awake),
        .i_repeatable  (r_cfg.repeat_mask[r_s1_src]),
        .i_cfg         (r_cfg),
        .i_entry       (s1_entry),
        .o_entry       (n_entry),
        .o_we          (n_we),
        .o_awake       (n_awake),
        .o_event       (n_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_awake <= 1'b0;
        end else if (s1_adv) begin
            r_display_awake <= n_awake;
        end
    end

    // output register
    t_kind       r_out_kind;
    logic [3:0]  r_out_action;
    logic [2:0]  r_out_src;
    logic [31:0] r_out_time;
    logic        r_out_ws;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= n_event.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && n_event.emit) begin
            r_out_kind   <= n_event.kind;
            r_out_action <= n_event.action;
            r_out_src    <= n_event.source;
            r_out_time   <= 32'(r_s1_now);
            r_out_ws     <= n_event.wake_supp;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_event_kind      = r_out_kind;
    assign o_action_code     = r_out_action;
    assign o_event_source    = r_out_src;
    assign o_timestamp       = r_out_time;
    assign o_wake_suppressed = r_out_ws;

    // checks
    `KDRS_ASSERT_NOW(a_stall_blocks_in, r_s1_valid && !s1_adv, !in_accept, "accept during stall")
    `KDRS_ASSERT_NOW(a_write_on_adv, mem_we, r_s1_valid && !r_s1_cmd && r_s1_in_range,
        "state write without a sample word")
    `KDRS_ASSERT_NOW(a_action_range, o_out_valid, o_action_code <= ACT_WAKE,
        "action code out of range")
    `KDRS_ASSERT_NOW(a_wake_form, o_out_valid && o_wake_suppressed,
        o_event_kind == KIND_PRESS && o_action_code == ACT_WAKE, "malformed wake word")
    `KDRS_ASSERT_NEXT(a_wake_sets_awake, s1_adv && n_event.emit && n_event.wake_supp,
        r_display_awake, "wake did not set display awake")

endmodule

`default_nettype wire
